### rtl/rfidpk_pkg.sv
// ----------------------------------------------------------------------------
// RFID tag table peak tracker package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package rfidpk_pkg;

  // Strength is this value minus the raw signal byte.
  localparam logic [7:0] STRENGTH_FULL = 8'hFF;

  // Width of the entry index on the result port.
  localparam int OUT_IDX_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INSERT,
    ST_PEAK_RD,
    ST_PEAK_WR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture a new request
    logic search;   // read the next EPC entry and compare the previous one
    logic insert;   // write the EPC at the fill pointer
    logic peak_rd;  // read the peak entry of the chosen index
    logic peak_wr;  // update the peak entry and present the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_empty;  // no entry below the fill pointer
    logic hit;         // the compared entry matches the EPC
    logic last;        // the compared entry is the last one in range
  } dp_stat_t;

endpackage

### rtl/rfidpk_ctrl.sv
// ----------------------------------------------------------------------------
// RFID tag table peak tracker controller
// Sequences search, insert and peak update for one request at a time.
// ----------------------------------------------------------------------------
module rfidpk_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rfidpk_pkg::dp_stat_t stat,
  output rfidpk_pkg::dp_cmd_t  cmd,
  output rfidpk_pkg::state_t   state,
  output logic                busy
);
  import rfidpk_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = stat.fill_empty ? ST_INSERT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat.hit) begin
          state_nxt = ST_PEAK_RD;
        end else if (stat.last) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT:  state_nxt = ST_PEAK_RD;
      ST_PEAK_RD: state_nxt = ST_PEAK_WR;
      ST_PEAK_WR: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:    cmd.load    = start;
      ST_SEARCH:  cmd.search  = 1'b1;
      ST_INSERT:  cmd.insert  = 1'b1;
      ST_PEAK_RD: cmd.peak_rd = 1'b1;
      ST_PEAK_WR: cmd.peak_wr = 1'b1;
      default:    cmd = '0;
    endcase
  end

  assign state = state_r;
  assign busy  = (state_r != ST_IDLE);

endmodule

### rtl/rfidpk_dp.sv
// ----------------------------------------------------------------------------
// RFID tag table peak tracker datapath
// EPC table, peak table, fill pointer, report counter and result registers.
// ----------------------------------------------------------------------------
module rfidpk_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rfidpk_pkg::dp_cmd_t                 cmd,
  output rfidpk_pkg::dp_stat_t                stat,
  input  logic [63:0]                         in_epc_low,
  input  logic [31:0]                         in_epc_high,
  input  logic [7:0]                          in_rssi_raw,
  input  logic [7:0]                          in_angle,
  output logic                                out_valid,
  output logic [rfidpk_pkg::OUT_IDX_W-1:0]    out_entry_index,
  output logic                                out_is_new,
  output logic [7:0]                          out_strength,
  output logic [7:0]                          out_peak_strength,
  output logic [7:0]                          out_peak_angle,
  output logic [15:0]                         out_report_total
);
  import rfidpk_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

  // Tables
  logic [95:0] epc_mem [TABLE_ENTRIES];
  logic [15:0] pk_mem  [TABLE_ENTRIES];   // {peak strength, peak angle}
  logic [TABLE_ENTRIES-1:0] pk_valid_r;

  // Request registers
  logic [95:0]      key_r;
  logic [7:0]       str_r;
  logic [7:0]       ang_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic             cmp_valid_r;
  logic [95:0]      epc_rdata_r;
  logic [IDX_W-1:0] idx_r;
  logic             is_new_r;
  logic [15:0]      pk_rdata_r;
  logic             pk_rvalid_r;

  // Persistent control state
  logic [IDX_W-1:0] fill_r;
  logic [15:0]      rpt_r;

  // Results
  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic                 out_new_r;
  logic [7:0]           out_str_r;
  logic [7:0]           out_pk_str_r;
  logic [7:0]           out_pk_ang_r;
  logic [15:0]          out_rpt_r;

  logic                       match;
  logic [7:0]                 cur_pk_str;
  logic [7:0]                 cur_pk_ang;
  logic                       raise;
  logic [IDX_W+OUT_IDX_W-1:0] idx_ext;

  assign match = cmp_valid_r && (epc_rdata_r == key_r);

  always_comb begin
    stat            = '0;
    stat.fill_empty = (fill_r == '0);
    stat.hit        = match;
    stat.last       = cmp_valid_r && (cmp_idx_r == fill_r - IDX_W'(1));
  end

  // An entry whose peak was never written reads as zero.
  assign cur_pk_str = pk_rvalid_r ? pk_rdata_r[15:8] : 8'h00;
  assign cur_pk_ang = pk_rvalid_r ? pk_rdata_r[7:0]  : 8'h00;
  assign raise      = (str_r > cur_pk_str);
  assign idx_ext    = {{OUT_IDX_W{1'b0}}, idx_r};

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rpt_r       <= '0;
      pk_valid_r  <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.peak_wr;
      if (cmd.load) begin
        rpt_r       <= rpt_r + 16'd1;
        cmp_valid_r <= 1'b0;
      end else if (cmd.search) begin
        cmp_valid_r <= 1'b1;
      end
      if (cmd.insert) begin
        fill_r <= (fill_r == IDX_LAST) ? '0 : fill_r + IDX_W'(1);
      end
      if (cmd.peak_wr && raise) begin
        pk_valid_r[idx_r] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= {in_epc_high, in_epc_low};
      str_r     <= STRENGTH_FULL - in_rssi_raw;
      ang_r     <= in_angle;
      rd_addr_r <= '0;
    end
    if (cmd.search) begin
      rd_addr_r <= rd_addr_r + IDX_W'(1);
      cmp_idx_r <= rd_addr_r;
      if (match) begin
        idx_r    <= cmp_idx_r;
        is_new_r <= 1'b0;
      end
    end
    if (cmd.insert) begin
      idx_r    <= fill_r;
      is_new_r <= 1'b1;
    end
    if (cmd.peak_rd) begin
      pk_rvalid_r <= pk_valid_r[idx_r];
    end
    if (cmd.peak_wr) begin
      out_idx_r    <= idx_ext[OUT_IDX_W-1:0];
      out_new_r    <= is_new_r;
      out_str_r    <= str_r;
      out_pk_str_r <= raise ? str_r : cur_pk_str;
      out_pk_ang_r <= raise ? ang_r : cur_pk_ang;
      out_rpt_r    <= rpt_r;
    end
  end

  // EPC table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      epc_mem[fill_r] <= key_r;
    end
    if (cmd.search) begin
      epc_rdata_r <= epc_mem[rd_addr_r];
    end
  end

  // Peak table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.peak_wr && raise) begin
      pk_mem[idx_r] <= {str_r, ang_r};
    end
    if (cmd.peak_rd) begin
      pk_rdata_r <= pk_mem[idx_r];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_entry_index   = out_idx_r;
  assign out_is_new        = out_new_r;
  assign out_strength      = out_str_r;
  assign out_peak_strength = out_pk_str_r;
  assign out_peak_angle    = out_pk_ang_r;
  assign out_report_total  = out_rpt_r;

endmodule

### rtl/rfid_tag_table_peak_tracker.sv
// ----------------------------------------------------------------------------
// RFID tag table peak tracker
// Looks up each tag report in a table of EPCs, inserts unknown tags and
// tracks the peak signal strength and its antenna angle per entry.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then
// compares the EPC against the stored entries below the fill pointer, one
// entry per cycle through the registered read port of the EPC table, and
// stops at the first match. A request with no match is written at the fill
// pointer, which wraps to zero at TABLE_ENTRIES. A request keeps busy high
// through the search, which is skipped when the table is empty, then the
// insert when no entry matched, then the peak read and the peak write; the
// length of the sequential search sets how long busy stays high. The
// result appears on the out_ ports for exactly one cycle, marked by
// out_valid, in the first cycle in which busy is low again. The receiver
// cannot stall the block, so the result must be captured in that cycle. The
// EPC and peak tables come up without initialization; the peak table
// carries one valid bit per entry, so a peak that was never written reads
// as zero and no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module rfid_tag_table_peak_tracker #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [63:0]                      in_epc_low,
  input  logic [31:0]                      in_epc_high,
  input  logic [7:0]                       in_rssi_raw,
  input  logic [7:0]                       in_angle,
  output logic                             out_valid,
  output logic [rfidpk_pkg::OUT_IDX_W-1:0] out_entry_index,
  output logic                             out_is_new,
  output logic [7:0]                       out_strength,
  output logic [7:0]                       out_peak_strength,
  output logic [7:0]                       out_peak_angle,
  output logic [15:0]                      out_report_total
);
  import rfidpk_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  state_t   state;

  // The controller walks the request through its steps.
  rfidpk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .state (state),
    .busy  (busy)
  );

  // The datapath holds both tables, the counters and the result registers.
  rfidpk_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_epc_low        (in_epc_low),
    .in_epc_high       (in_epc_high),
    .in_rssi_raw       (in_rssi_raw),
    .in_angle          (in_angle),
    .out_valid         (out_valid),
    .out_entry_index   (out_entry_index),
    .out_is_new        (out_is_new),
    .out_strength      (out_strength),
    .out_peak_strength (out_peak_strength),
    .out_peak_angle    (out_peak_angle),
    .out_report_total  (out_report_total)
  );

  // A result only follows the peak update step.
  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state == ST_PEAK_WR))
    else $error("result strobe without a peak update");

  // An accepted request makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The peak after the update can never be below the new strength.
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_peak_strength >= out_strength))
    else $error("peak strength below reported strength");

  // The block is idle again when the result is presented.
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result presented while still busy");

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the RFID tag table peak tracker
// Drives tag reports through the start/busy request port, predicts every
// result with a behavioral copy of the tag table, and checks each strobed
// result field by field: directed rows first, then random traffic built
// around a small pool of recurring tags.
// ----------------------------------------------------------------------------
module tb_top;
  import rfidpk_pkg::*;

  // Table size of the block under test. The predictor keeps its own copy.
  localparam int TAG_SLOTS = 16;
  // Chance, in percent, that the sender pauses before raising a request.
  localparam int IDLE_PCT = 8;
  // Longest pause the sender takes; longer than a full-table search.
  localparam int IDLE_MAX = 24;
  // Random requests after the directed rows, and the range of them that is
  // sent back to back with no pauses at all.
  localparam int RANDOM_REQS = 1050;
  localparam int CALM_FIRST = 400;
  localparam int CALM_LAST = 650;
  // Recurring tags that the random part draws from. It is larger than the
  // table, so tags are found, evicted by the wrap and inserted again.
  localparam int POOL_SIZE = 24;
  // Idle cycles after the last result: more than one full-table request.
  localparam int TAIL_CYCLES = 48;
  // The slowest correct run is about 1100 requests at the worst pause plus
  // a full search each; the limit allows about four times its length.
  localparam int CYCLE_LIMIT = 200_000;
  // Mismatch messages beyond this many are counted but not printed.
  localparam int REPORT_CAP = 200;

  typedef struct packed {
    logic [63:0] epc_low;
    logic [31:0] epc_high;
    logic [7:0]  rssi_raw;
    logic [7:0]  angle;
  } tag_report_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 is_new;
    logic [7:0]           strength;
    logic [7:0]           peak_strength;
    logic [7:0]           peak_angle;
    logic [15:0]          report_total;
  } tag_update_t;

  // One row of the directed part. When pinned is set the row carries its
  // own result, read straight off the behavior; otherwise the predictor
  // supplies it.
  typedef struct packed {
    tag_report_t report;
    logic        pinned;
    tag_update_t update;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_epc_low;
  logic [31:0] in_epc_high;
  logic [7:0]  in_rssi_raw;
  logic [7:0]  in_angle;

  logic                 out_valid;
  logic [OUT_IDX_W-1:0] out_entry_index;
  logic                 out_is_new;
  logic [7:0]           out_strength;
  logic [7:0]           out_peak_strength;
  logic [7:0]           out_peak_angle;
  logic [15:0]          out_report_total;

  rfid_tag_table_peak_tracker #(
    .TABLE_ENTRIES(TAG_SLOTS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epc_low       (in_epc_low),
    .in_epc_high      (in_epc_high),
    .in_rssi_raw      (in_rssi_raw),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_entry_index  (out_entry_index),
    .out_is_new       (out_is_new),
    .out_strength     (out_strength),
    .out_peak_strength(out_peak_strength),
    .out_peak_angle   (out_peak_angle),
    .out_report_total (out_report_total)
  );

  // --------------------------------------------------------------------------
  // Clock and watchdog.
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #6 clk = ~clk;

  int cycle_count = 0;

  // A hung block or a lost result ends the run here with a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: a behavioral copy of the tag table.
  // The EPC and strength stores are only read below the fill pointer, so
  // their unwritten contents never matter. The peak stores start at zero.
  // --------------------------------------------------------------------------
  logic [31:0] epc_hi_tab   [TAG_SLOTS];
  logic [63:0] epc_lo_tab   [TAG_SLOTS];
  logic [7:0]  strength_tab [TAG_SLOTS];
  logic [7:0]  peak_str_tab [TAG_SLOTS];
  logic [7:0]  peak_ang_tab [TAG_SLOTS];
  int          fill_ptr;
  logic [15:0] report_cnt;

  initial begin
    for (int k = 0; k < TAG_SLOTS; k++) begin
      epc_hi_tab[k]   = '0;
      epc_lo_tab[k]   = '0;
      strength_tab[k] = '0;
      peak_str_tab[k] = '0;
      peak_ang_tab[k] = '0;
    end
    fill_ptr   = 0;
    report_cnt = '0;
  end

  // Applies one accepted request to the table and returns the result the
  // block must produce for it.
  function automatic tag_update_t track_report(tag_report_t r);
    tag_update_t u;
    logic [7:0]  str;
    int          slot;
    bit          hit;
    str  = STRENGTH_FULL - r.rssi_raw;
    hit  = 1'b0;
    slot = fill_ptr;
    // Linear search below the fill pointer; the first match wins.
    for (int k = 0; k < fill_ptr; k++) begin
      if (!hit && epc_lo_tab[k] == r.epc_low && epc_hi_tab[k] == r.epc_high) begin
        hit  = 1'b1;
        slot = k;
      end
    end
    // A new tag takes the slot at the fill pointer. The peak of whatever
    // lived there before is deliberately left in place.
    if (!hit) begin
      epc_lo_tab[slot] = r.epc_low;
      epc_hi_tab[slot] = r.epc_high;
      fill_ptr = (fill_ptr + 1 >= TAG_SLOTS) ? 0 : fill_ptr + 1;
    end
    strength_tab[slot] = str;
    report_cnt = report_cnt + 16'd1;
    // The peak only moves on a strictly stronger report.
    if (str > peak_str_tab[slot]) begin
      peak_str_tab[slot] = str;
      peak_ang_tab[slot] = r.angle;
    end
    u.entry_index   = OUT_IDX_W'(slot);
    u.is_new        = !hit;
    u.strength      = strength_tab[slot];
    u.peak_strength = peak_str_tab[slot];
    u.peak_angle    = peak_ang_tab[slot];
    u.report_total  = report_cnt;
    return u;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking.
  // Only one request is in flight at a time, but the queue keeps the order
  // explicit and catches strobes that arrive with nothing outstanding.
  // --------------------------------------------------------------------------
  tag_update_t updates_due[$];
  int          mismatches = 0;

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  // Outputs are sampled at the rising edge, before the block's own updates
  // for that edge land, so each strobe is seen in the cycle it covers.
  always @(posedge clk) begin : result_monitor
    tag_update_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (updates_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $error("result strobe with no request outstanding (entry_index 0x%0h)",
                 out_entry_index);
      end else begin
        want = updates_due.pop_front();
        check_field("out_valid", 16'd1, {15'd0, out_valid});
        check_field("entry_index", 16'(want.entry_index), 16'(out_entry_index));
        check_field("is_new", 16'(want.is_new), 16'(out_is_new));
        check_field("strength", 16'(want.strength), 16'(out_strength));
        check_field("peak_strength", 16'(want.peak_strength), 16'(out_peak_strength));
        check_field("peak_angle", 16'(want.peak_angle), 16'(out_peak_angle));
        check_field("report_total", want.report_total, out_report_total);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver.
  // --------------------------------------------------------------------------

  // While start is low the payload ports carry junk, so a block that
  // captures them outside the accepting edge shows up as a mismatch.
  task automatic drive_junk();
    in_epc_low  <= {$urandom, $urandom};
    in_epc_high <= $urandom;
    in_rssi_raw <= 8'($urandom);
    in_angle    <= 8'($urandom);
  endtask

  // Sends one request and records what it must produce. Called in the time
  // step of a rising edge; returns in the step of the edge that took it.
  // The optional pause before start rises has a random length, so over the
  // run it ends at every point of the previous request's search.
  task automatic send_report(input tag_report_t r, input bit pinned,
                             input tag_update_t pinned_update, input bit may_idle);
    tag_update_t predicted;
    if (may_idle && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      repeat ($urandom_range(IDLE_MAX, 1)) begin
        drive_junk();
        @(posedge clk);
      end
    end
    start       <= 1'b1;
    in_epc_low  <= r.epc_low;
    in_epc_high <= r.epc_high;
    in_rssi_raw <= r.rssi_raw;
    in_angle    <= r.angle;
    // The request is taken at the first edge where busy is seen low.
    do @(posedge clk); while (busy !== 1'b0);
    // The predictor always runs, so a pinned row still advances the table.
    predicted = track_report(r);
    updates_due.push_back(pinned ? pinned_update : predicted);
  endtask

  function automatic tag_report_t make_report(logic [31:0] hi, logic [63:0] lo,
                                              logic [7:0] raw, logic [7:0] ang);
    tag_report_t r;
    r.epc_low  = lo;
    r.epc_high = hi;
    r.rssi_raw = raw;
    r.angle    = ang;
    return r;
  endfunction

  function automatic directed_row_t pinned_row(logic [31:0] hi, logic [63:0] lo,
                                               logic [7:0] raw, logic [7:0] ang,
                                               int idx, bit fresh, logic [7:0] str,
                                               logic [7:0] pk, logic [7:0] pa,
                                               int total);
    directed_row_t d;
    d.report               = make_report(hi, lo, raw, ang);
    d.pinned               = 1'b1;
    d.update.entry_index   = OUT_IDX_W'(idx);
    d.update.is_new        = fresh;
    d.update.strength      = str;
    d.update.peak_strength = pk;
    d.update.peak_angle    = pa;
    d.update.report_total  = 16'(total);
    return d;
  endfunction

  function automatic directed_row_t open_row(logic [31:0] hi, logic [63:0] lo,
                                             logic [7:0] raw, logic [7:0] ang);
    directed_row_t d;
    d.report = make_report(hi, lo, raw, ang);
    d.pinned = 1'b0;
    d.update = '0;
    return d;
  endfunction

  directed_row_t directed_rows[$];
  logic [95:0]   tag_pool[POOL_SIZE];

  initial begin : stimulus
    logic [95:0] epc;
    tag_report_t r;
    int          pick;

    // Every input is known from time zero, with reset held low at first.
    rst_n       = 1'b0;
    start       = 1'b0;
    in_epc_low  = '0;
    in_epc_high = '0;
    in_rssi_raw = '0;
    in_angle    = '0;

    // Directed rows. Tag A is all zeros, tag B all ones, tags C and D differ
    // from them only in the upper or lower word, so the compare is exercised
    // on both halves of the EPC.
    // Table fills from an empty pointer; a zero strength does not raise a
    // zero peak.
    directed_rows.push_back(pinned_row(32'h0, 64'h0, 8'hFF, 8'h00,
                                       0, 1'b1, 8'h00, 8'h00, 8'h00, 1));
    directed_rows.push_back(pinned_row(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'hFF,
                                       1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 2));
    directed_rows.push_back(pinned_row(32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h80, 8'h12,
                                       2, 1'b1, 8'h7F, 8'h7F, 8'h12, 3));
    directed_rows.push_back(pinned_row(32'hFFFF_FFFF, 64'h0, 8'h01, 8'h34,
                                       3, 1'b1, 8'hFE, 8'hFE, 8'h34, 4));
    // Tag A again: a stronger report raises the peak, an equal one does not
    // move the angle, and a weaker one leaves the peak alone.
    directed_rows.push_back(pinned_row(32'h0, 64'h0, 8'h00, 8'hAA,
                                       0, 1'b0, 8'hFF, 8'hFF, 8'hAA, 5));
    directed_rows.push_back(pinned_row(32'h0, 64'h0, 8'h00, 8'h55,
                                       0, 1'b0, 8'hFF, 8'hFF, 8'hAA, 6));
    directed_rows.push_back(pinned_row(32'h0, 64'h0, 8'h10, 8'h66,
                                       0, 1'b0, 8'hEF, 8'hFF, 8'hAA, 7));
    directed_rows.push_back(pinned_row(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'h01,
                                       1, 1'b0, 8'h00, 8'hFF, 8'hFF, 8));
    // Near misses of tag A in a single bit of either word.
    directed_rows.push_back(open_row(32'h0, 64'h1, 8'h7F, 8'hC3));
    directed_rows.push_back(open_row(32'h8000_0000, 64'h0, 8'h40, 8'h3C));
    // Ten more tags fill entries 6 to 15, after which the pointer wraps.
    directed_rows.push_back(open_row(32'h1357_9BDF, 64'h0123_4567_89AB_CDEF, 8'h11, 8'h01));
    directed_rows.push_back(open_row(32'h2468_ACE0, 64'hFEDC_BA98_7654_3210, 8'h22, 8'h02));
    directed_rows.push_back(open_row(32'h0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 8'h33, 8'h04));
    directed_rows.push_back(open_row(32'hF0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F, 8'h44, 8'h08));
    directed_rows.push_back(open_row(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 8'h10));
    directed_rows.push_back(open_row(32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 8'h66, 8'h20));
    directed_rows.push_back(open_row(32'h0000_0001, 64'h8000_0000_0000_0000, 8'h77, 8'h40));
    directed_rows.push_back(open_row(32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 8'h88, 8'h80));
    directed_rows.push_back(open_row(32'hDEAD_BEEF, 64'hCAFE_F00D_1234_5678, 8'h99, 8'hFE));
    directed_rows.push_back(open_row(32'h3C3C_C3C3, 64'h9669_6996_A55A_5AA5, 8'hAA, 8'h7F));
    // After the wrap nothing is below the pointer, so tag A is inserted
    // again at entry 0 and inherits the old peak of that entry.
    directed_rows.push_back(pinned_row(32'h0, 64'h0, 8'h20, 8'h99,
                                       0, 1'b1, 8'hDF, 8'hFF, 8'hAA, 21));
    directed_rows.push_back(pinned_row(32'h0, 64'h0, 8'h00, 8'h11,
                                       0, 1'b0, 8'hFF, 8'hFF, 8'hAA, 22));
    // Tag B still sits in entry 1, but entry 1 is at the pointer now, so it
    // is written again and keeps the peak it had.
    directed_rows.push_back(pinned_row(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h22,
                                       1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 23));
    // Tag C is reinserted over its own stale entry and now beats its old peak.
    directed_rows.push_back(pinned_row(32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 8'h5E,
                                       2, 1'b1, 8'hFF, 8'hFF, 8'h5E, 24));

    for (int k = 0; k < POOL_SIZE; k++)
      tag_pool[k] = {$urandom, $urandom, $urandom};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k])
      send_report(directed_rows[k].report, directed_rows[k].pinned,
                  directed_rows[k].update, 1'b1);

    // Random part. Most requests reuse a pool tag, so hits land at every
    // depth of the search and evicted tags come back as new inserts. Some
    // are one-bit neighbors of a pool tag, the rest fresh random tags.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(99);
      if (pick < 75)
        epc = tag_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 85)
        epc = tag_pool[$urandom_range(POOL_SIZE - 1)] ^ (96'd1 << $urandom_range(95));
      else
        epc = {$urandom, $urandom, $urandom};
      // Let the population of recurring tags drift slowly.
      if ($urandom_range(99) < 3)
        tag_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom, $urandom};
      r = make_report(epc[95:64], epc[63:0], 8'($urandom), 8'($urandom));
      send_report(r, 1'b0, '0, !(n >= CALM_FIRST && n < CALM_LAST));
    end

    start <= 1'b0;
    while (updates_due.size() != 0)
      @(posedge clk);
    // Any stray strobe after the last result is caught by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && updates_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
rtl/rfidpk_pkg.sv
rtl/rfidpk_ctrl.sv
rtl/rfidpk_dp.sv
rtl/rfid_tag_table_peak_tracker.sv
tb/tb_top.sv
